// ===== hw/rtl/twjsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twjsm_pkg
// Shared types and constants of the two-wire JTAG slot master.
// ----------------------------------------------------------------------------
package twjsm_pkg;

  // Input mode codes. Zero is a tick, every other code is a command.
  localparam logic [2:0] ModeTick     = 3'd0;
  localparam logic [2:0] ModeResetTap = 3'd1;
  localparam logic [2:0] ModeIrShift8 = 3'd2;
  localparam logic [2:0] ModeDrShift16 = 3'd3;
  localparam logic [2:0] ModeDrShift20 = 3'd4;
  localparam logic [2:0] ModeSetTclk  = 3'd5;
  localparam logic [2:0] ModeClrTclk  = 3'd6;
  localparam logic [2:0] ModeStrobes  = 3'd7;

  // The operation register reuses the mode codes; zero means idle.
  localparam logic [2:0] OpIdle = 3'd0;

  localparam int unsigned WordWidth = 20;
  localparam int unsigned ClkWidth  = 5;

  // Bit positions of the first bit sent for each shift length.
  localparam int unsigned Msb8Bit  = 7;
  localparam int unsigned Msb16Bit = 15;
  localparam int unsigned Msb20Bit = 19;

  // One result transaction: the drive plan for one clock-low slot.
  typedef struct packed {
    logic                 level_at_fall;
    logic                 level_at_rise;
    logic                 line_driven;
    logic                 op_done;
    logic [WordWidth-1:0] captured_word;
  } twjsm_result_t;

endpackage

// ===== hw/rtl/twjsm_out_buf.sv =====
// ----------------------------------------------------------------------------
// twjsm_out_buf
// Output register with a skid stage, so the slot logic keeps running while
// a finished result waits for the receiver.
// ----------------------------------------------------------------------------
module twjsm_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  twjsm_pkg::twjsm_result_t push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output twjsm_pkg::twjsm_result_t out_data_o
);
  import twjsm_pkg::*;

  logic          main_valid_q, main_valid_d;
  logic          skid_valid_q, skid_valid_d;
  twjsm_result_t main_q, main_d;
  twjsm_result_t skid_q, skid_d;
  logic          pop;

  assign pop = main_valid_q && !out_stall_i;

  // The producer only pushes while the skid stage is empty.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ===== hw/rtl/two_wire_jtag_slot_master.sv =====
// ----------------------------------------------------------------------------
// two_wire_jtag_slot_master
// Slot-level master for a two-wire JTAG link (clock plus one shared data line).
// ----------------------------------------------------------------------------
// Usage: the input channel carries commands and ticks. A command (TAP reset,
// IR shift of 8 bits, DR shift of 16 or 20 bits, set TCLK, clear TCLK, or a
// run of TCLK strobes) loads an operation and returns no result. Each later
// tick transaction yields one result transaction that describes one clock-low
// slot: the drive level at the clock fall, the level just before the rise,
// whether the master drives the line, a done flag on the last slot, and the
// captured TDO word on the last slot of a shift. A command sent while an
// operation is running is dropped, and a tick while idle is dropped too.
// Throughput is one transaction per cycle unless the input stalls; a tick's
// result is registered on its way out. The slot decode and state update are
// a single pass of logic between the operation registers and the output
// register. When the receiver stalls, a skid stage holds one more result, and
// only then does the input stall, so stalls back up without loss. Reset
// leaves the block idle with the kept TCLK level high and no pending result.
// ----------------------------------------------------------------------------
module two_wire_jtag_slot_master #(
  parameter int unsigned STROBE_COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    mode_i,
  input  logic [19:0]                   shift_data_i,
  input  logic [STROBE_COUNT_WIDTH-1:0] strobe_count_i,
  input  logic                          line_sample_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          level_at_fall_o,
  output logic                          level_at_rise_o,
  output logic                          line_driven_o,
  output logic                          op_done_o,
  output logic [19:0]                   captured_word_o
);
  import twjsm_pkg::*;

  // Operation state. The slot position is kept as a JTAG clock index and a
  // slot-within-clock index (0 TMS, 1 TDI, 2 released TDO).
  logic                          tclk_q, tclk_d;
  logic [2:0]                    op_q, op_d;
  logic [WordWidth-1:0]          shift_q, shift_d;
  logic [WordWidth-1:0]          cap_q, cap_d;
  logic [ClkWidth-1:0]           clk_cnt_q, clk_cnt_d;
  logic [1:0]                    sub_q, sub_d;
  logic [STROBE_COUNT_WIDTH-1:0] strobes_q, strobes_d;

  logic          in_acc;
  logic          busy;
  logic          is_cmd;
  logic          tick;
  logic          shift_op;
  logic          ldh_ok;
  logic          read_slot;
  logic          tms;
  logic          tdi;
  logic          msb_bit;
  logic          last_slot;
  logic [ClkWidth-1:0] last_clk;
  logic [ClkWidth-1:0] pre_n;
  logic [ClkWidth-1:0] end_n;
  twjsm_result_t res;
  twjsm_result_t out_data;
  logic          buf_full;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign busy       = (op_q != OpIdle);
  assign is_cmd     = (mode_i != ModeTick);
  assign tick       = in_acc && !is_cmd && busy;
  assign shift_op   = (op_q == ModeIrShift8) || (op_q == ModeDrShift16) ||
                      (op_q == ModeDrShift20);
  assign ldh_ok     = (op_q == ModeSetTclk) || (op_q == ModeClrTclk) ||
                      (op_q == ModeStrobes);

  // Index of the final JTAG clock of each operation.
  always_comb begin
    unique case (op_q)
      ModeResetTap:  last_clk = ClkWidth'(6);
      ModeIrShift8:  last_clk = ClkWidth'(13);
      ModeDrShift16: last_clk = ClkWidth'(20);
      ModeDrShift20: last_clk = ClkWidth'(24);
      ModeStrobes:   last_clk = ClkWidth'(1);
      default:       last_clk = ClkWidth'(0);
    endcase
  end

  // Scan geometry: clocks before the data bits, and the clock after them.
  always_comb begin
    unique case (op_q)
      ModeIrShift8: begin
        pre_n   = ClkWidth'(4);
        end_n   = ClkWidth'(12);
        msb_bit = shift_q[Msb8Bit];
      end
      ModeDrShift16: begin
        pre_n   = ClkWidth'(3);
        end_n   = ClkWidth'(19);
        msb_bit = shift_q[Msb16Bit];
      end
      default: begin
        pre_n   = ClkWidth'(3);
        end_n   = ClkWidth'(23);
        msb_bit = shift_q[Msb20Bit];
      end
    endcase
  end

  // TMS and TDI for the current JTAG clock.
  always_comb begin
    tms       = 1'b0;
    tdi       = 1'b0;
    read_slot = 1'b0;
    if (op_q == ModeResetTap) begin
      tms = (clk_cnt_q < ClkWidth'(6));
      tdi = 1'b1;
    end else if (shift_op) begin
      if (clk_cnt_q < pre_n) begin
        // Walk from run-test/idle to the shift state.
        if (op_q == ModeIrShift8) begin
          tms = (clk_cnt_q < ClkWidth'(2));
        end else begin
          tms = (clk_cnt_q < ClkWidth'(1));
        end
        tdi = (clk_cnt_q == '0) ? tclk_q : 1'b1;
      end else if (clk_cnt_q < end_n) begin
        // Data bits; TMS rises on the last one to leave the shift state.
        tms       = (clk_cnt_q == end_n - ClkWidth'(1));
        tdi       = msb_bit;
        read_slot = 1'b1;
      end else if (clk_cnt_q == end_n) begin
        tms = 1'b1;
        tdi = 1'b1;
      end else begin
        tms = 1'b0;
        tdi = tclk_q;
      end
    end else begin
      // Set, clear, or one half of a strobe pair: TDI carries the new TCLK.
      tms = 1'b0;
      tdi = (op_q == ModeSetTclk) || ((op_q == ModeStrobes) && (clk_cnt_q == '0));
    end
  end

  assign last_slot = (sub_q == 2'd2) && (clk_cnt_q == last_clk);

  always_comb begin
    tclk_d    = tclk_q;
    op_d      = op_q;
    shift_d   = shift_q;
    cap_d     = cap_q;
    clk_cnt_d = clk_cnt_q;
    sub_d     = sub_q;
    strobes_d = strobes_q;

    res.level_at_fall = 1'b0;
    res.level_at_rise = 1'b0;
    res.line_driven   = 1'b1;
    res.op_done       = 1'b0;
    res.captured_word = '0;

    if (in_acc && is_cmd && !busy) begin
      op_d      = mode_i;
      clk_cnt_d = '0;
      sub_d     = '0;
      cap_d     = '0;
      shift_d   = shift_data_i;
      if (mode_i == ModeStrobes) begin
        strobes_d = strobe_count_i;
        if (strobe_count_i == '0) begin
          op_d = OpIdle;
        end
      end
    end else if (tick) begin
      unique case (sub_q)
        2'd0: begin
          // With TCLK high the TMS slot dips low and comes back high.
          if (ldh_ok && tclk_q) begin
            res.level_at_rise = 1'b1;
          end else begin
            res.level_at_fall = tms;
            res.level_at_rise = tms;
          end
        end
        2'd1: begin
          res.level_at_fall = tdi;
          res.level_at_rise = tdi;
          if (read_slot) begin
            shift_d = {shift_q[WordWidth-2:0], 1'b0};
          end
        end
        default: begin
          res.line_driven = 1'b0;
          if (read_slot) begin
            cap_d = {cap_q[WordWidth-2:0], line_sample_i};
          end
          if (ldh_ok) begin
            tclk_d = tdi;
          end
        end
      endcase

      if (!last_slot) begin
        if (sub_q == 2'd2) begin
          sub_d     = 2'd0;
          clk_cnt_d = clk_cnt_q + ClkWidth'(1);
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end else begin
        clk_cnt_d = '0;
        sub_d     = '0;
        if (op_q == ModeStrobes) begin
          strobes_d = strobes_q - STROBE_COUNT_WIDTH'(1);
          if (strobes_q == STROBE_COUNT_WIDTH'(1)) begin
            res.op_done = 1'b1;
            op_d        = OpIdle;
          end
        end else begin
          res.op_done = 1'b1;
          op_d        = OpIdle;
          if (op_q == ModeDrShift20) begin
            // The 20-bit capture comes out with its low nibble on top.
            res.captured_word = {cap_q[3:0], cap_q[WordWidth-1:4]};
          end else if (shift_op) begin
            res.captured_word = cap_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tclk_q    <= 1'b1;
      op_q      <= OpIdle;
      shift_q   <= '0;
      cap_q     <= '0;
      clk_cnt_q <= '0;
      sub_q     <= '0;
      strobes_q <= '0;
    end else begin
      tclk_q    <= tclk_d;
      op_q      <= op_d;
      shift_q   <= shift_d;
      cap_q     <= cap_d;
      clk_cnt_q <= clk_cnt_d;
      sub_q     <= sub_d;
      strobes_q <= strobes_d;
    end
  end

  twjsm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign level_at_fall_o = out_data.level_at_fall;
  assign level_at_rise_o = out_data.level_at_rise;
  assign line_driven_o   = out_data.line_driven;
  assign op_done_o       = out_data.op_done;
  assign captured_word_o = out_data.captured_word;

  // An idle block always sits at the first slot of its next operation.
  a_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OpIdle) |-> ((clk_cnt_q == '0) && (sub_q == 2'd0)))
    else $error("idle with a nonzero slot position");

  // The slot-within-clock index never reaches its unused code.
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("slot index out of range");

  // A running strobe command always has at least one pair left.
  a_strobes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == ModeStrobes) |-> (strobes_q != '0))
    else $error("strobe command running with no pairs left");

  // The input only stalls while a result is waiting at the output.
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

endmodule

// ===== verif/tb_two_wire_jtag_slot_master.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_wire_jtag_slot_master
// Self-checking bench for the two-wire JTAG slot master. A short table of
// directed commands and ticks is followed by random command runs. Every
// accepted transaction goes through a slot-level model of the scan engine,
// and the output transactions are scored in order against it or a typed row.
// ----------------------------------------------------------------------------
module tb_two_wire_jtag_slot_master;
  import twjsm_pkg::*;

  localparam int unsigned StrobeWidth = 16;
  localparam int          RandomItems = 450;
  localparam int          CycleLimit  = 200000;
  localparam int          DrainCycles = 20;

  // Where the expectation of a directed row comes from. Typed rows carry a
  // hand-written result, silent rows must give no result at all, and every
  // other transaction is scored against the slot model.
  typedef enum logic [1:0] {
    ExpFromModel,
    ExpSilent,
    ExpTyped
  } exp_src_e;

  typedef struct packed {
    logic [2:0]             mode;
    logic [19:0]            data;
    logic [StrobeWidth-1:0] count;
    logic                   sample;
    exp_src_e               src;
    twjsm_result_t          res;
  } stim_row_t;

  localparam int NumRows = 26;

  // Directed walk: idle ticks, zero strobes, set TCLK from both kept levels,
  // clear TCLK from high, the low-then-high TMS slot, a single strobe pair,
  // commands dropped while busy, the field extremes, and the start of a TAP
  // reset. The shift commands are left to the random part, which runs each
  // of them to completion.
  stim_row_t dir_rows [NumRows] = '{
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpSilent,    '0},
    '{ModeStrobes,   20'hFFFFF, 16'h0000, 1'b1, ExpSilent,    '0},
    '{ModeTick,      20'hFFFFF, 16'hFFFF, 1'b0, ExpSilent,    '0},
    '{ModeSetTclk,   20'h00000, 16'h0000, 1'b0, ExpSilent,    '0},
    '{ModeClrTclk,   20'hFFFFF, 16'hFFFF, 1'b1, ExpSilent,    '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpTyped,
      '{1'b0, 1'b1, 1'b1, 1'b0, 20'h00000}},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpTyped,
      '{1'b0, 1'b0, 1'b0, 1'b1, 20'h00000}},
    '{ModeClrTclk,   20'h00000, 16'h0000, 1'b0, ExpSilent,    '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeSetTclk,   20'hFFFFF, 16'h0000, 1'b1, ExpSilent,    '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeStrobes,   20'hFFFFF, 16'h0001, 1'b0, ExpSilent,    '0},
    '{ModeStrobes,   20'h00000, 16'hFFFF, 1'b1, ExpSilent,    '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpFromModel, '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b1, ExpFromModel, '0},
    '{ModeResetTap,  20'h00000, 16'h0000, 1'b0, ExpSilent,    '0},
    '{ModeTick,      20'h00000, 16'h0000, 1'b0, ExpTyped,
      '{1'b1, 1'b1, 1'b1, 1'b0, 20'h00000}}
  };

  // Clock, reset and the ports of the block. Every input starts at a known
  // value so nothing floats before the first driven edge.
  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [2:0]             mode_i         = ModeTick;
  logic [19:0]            shift_data_i   = '0;
  logic [StrobeWidth-1:0] strobe_count_i = '0;
  logic                   line_sample_i  = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic                   level_at_fall_o;
  logic                   level_at_rise_o;
  logic                   line_driven_o;
  logic                   op_done_o;
  logic [19:0]            captured_word_o;

  // Expectation source travels with the payload, so the scoreboard sees the
  // row that belongs to the transaction it accepts.
  exp_src_e      pin_src = ExpFromModel;
  twjsm_result_t pin_res = '0;

  // Slot model state: kept TCLK level, running operation, outgoing and
  // incoming shift words, slot index within the operation, strobes to go.
  logic                   tclk_m    = 1'b1;
  logic [2:0]             op_m      = OpIdle;
  logic [19:0]            shift_m   = '0;
  logic [19:0]            cap_m     = '0;
  logic [6:0]             slot_m    = '0;
  logic [StrobeWidth-1:0] strobes_m = '0;

  twjsm_result_t slot_q [$];
  int            err_cnt   = 0;
  int            cycles    = 0;
  int            n_items   = 0;
  int            drv_left  = 0;
  bit            drv_calm  = 1'b0;
  bit            stall_calm = 1'b0;

  two_wire_jtag_slot_master #(
    .STROBE_COUNT_WIDTH(StrobeWidth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .shift_data_i   (shift_data_i),
    .strobe_count_i (strobe_count_i),
    .line_sample_i  (line_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_at_fall_o(level_at_fall_o),
    .level_at_rise_o(level_at_rise_o),
    .line_driven_o  (line_driven_o),
    .op_done_o      (op_done_o),
    .captured_word_o(captured_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Number of line slots in one pass of an operation. A strobe pass is one
  // set/clear pair; the pass repeats for every strobe requested.
  function automatic int slots_of(input logic [2:0] op);
    case (op)
      ModeResetTap:  return 21;
      ModeIrShift8:  return 42;
      ModeDrShift16: return 63;
      ModeDrShift20: return 75;
      ModeSetTclk:   return 3;
      ModeClrTclk:   return 3;
      ModeStrobes:   return 6;
      default:       return 0;
    endcase
  endfunction

  // Advances the slot model by one input transaction. Returns 1 when the
  // transaction yields a result, which is then placed in res.
  function automatic bit scan_slot(input logic [2:0] mode, input logic [19:0] data,
                                   input logic [StrobeWidth-1:0] count,
                                   input logic sample, output twjsm_result_t res);
    int unsigned clk_n, sub, pre, len;
    logic        tms, tdi, low_high, rd, shf;
    logic [19:0] msb;
    res = '0;
    res.line_driven = 1'b1;
    // Commands load a new operation only while idle; otherwise they vanish.
    if (mode != ModeTick) begin
      if (op_m != OpIdle) return 1'b0;
      op_m    = mode;
      slot_m  = '0;
      cap_m   = '0;
      shift_m = data;
      if (mode == ModeStrobes) begin
        strobes_m = count;
        if (count == '0) op_m = OpIdle;
      end
      return 1'b0;
    end
    if (op_m == OpIdle) return 1'b0;

    clk_n    = slot_m / 3;
    sub      = slot_m % 3;
    shf      = (op_m == ModeIrShift8) || (op_m == ModeDrShift16) || (op_m == ModeDrShift20);
    tms      = 1'b0;
    tdi      = 1'b0;
    low_high = 1'b0;
    rd       = 1'b0;

    if (op_m == ModeResetTap) begin
      tms = (clk_n < 6);
      tdi = 1'b1;
    end else if (shf) begin
      pre = (op_m == ModeIrShift8) ? 4 : 3;
      len = (op_m == ModeIrShift8) ? 8 : (op_m == ModeDrShift16) ? 16 : 20;
      msb = 20'h1 << (len - 1);
      if (clk_n < pre) begin
        // Walk to the shift state; the first clock carries the kept TCLK.
        tms = (op_m == ModeIrShift8) ? (clk_n < 2) : (clk_n < 1);
        tdi = (clk_n == 0) ? tclk_m : 1'b1;
      end else if (clk_n < pre + len) begin
        tms = (clk_n == pre + len - 1);
        tdi = |(shift_m & msb);
        if (sub == 1) shift_m = shift_m << 1;
        rd = 1'b1;
      end else if (clk_n == pre + len) begin
        tms = 1'b1;
        tdi = 1'b1;
      end else begin
        tms = 1'b0;
        tdi = tclk_m;
      end
    end else begin
      // Set, clear, or one half of a strobe pair.
      tdi      = (op_m == ModeSetTclk) || (op_m == ModeStrobes && clk_n == 0);
      low_high = 1'b1;
    end

    case (sub)
      0: begin
        if (low_high && tclk_m) begin
          res.level_at_fall = 1'b0;
          res.level_at_rise = 1'b1;
        end else begin
          res.level_at_fall = tms;
          res.level_at_rise = tms;
        end
      end
      1: begin
        res.level_at_fall = tdi;
        res.level_at_rise = tdi;
      end
      default: begin
        res.line_driven = 1'b0;
        if (rd) cap_m = {cap_m[18:0], sample};
        if (low_high) tclk_m = tdi;
      end
    endcase

    slot_m = slot_m + 7'd1;
    if (slot_m >= slots_of(op_m)) begin
      if (op_m == ModeStrobes) begin
        strobes_m = strobes_m - 1'b1;
        slot_m    = '0;
        if (strobes_m == '0) begin
          res.op_done = 1'b1;
          op_m        = OpIdle;
        end
      end else begin
        res.op_done = 1'b1;
        if (shf) begin
          res.captured_word = cap_m;
          // The 20-bit capture comes back with its low nibble on top.
          if (op_m == ModeDrShift20) res.captured_word = {cap_m[3:0], cap_m[19:4]};
        end
        op_m   = OpIdle;
        slot_m = '0;
      end
    end
    return 1'b1;
  endfunction

  // Gap length for both the sender and the receiver: mostly none, sometimes
  // a short gap, now and then a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Sends one input transaction and returns at the edge where it is taken.
  // The sender also keeps a count of the slots still owed to the running
  // operation, so it knows whether a command will start or be dropped, and
  // it counts only transactions that the block does not ignore.
  task automatic send_item(input logic [2:0] mode, input logic [19:0] data,
                           input logic [StrobeWidth-1:0] count, input logic sample,
                           input exp_src_e src, input twjsm_result_t res);
    int gap;
    if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
    gap = drv_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    shift_data_i   <= data;
    strobe_count_i <= count;
    line_sample_i  <= sample;
    pin_src        <= src;
    pin_res        <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mode != ModeTick) begin
      if (drv_left == 0) begin
        drv_left = (mode == ModeStrobes) ? slots_of(mode) * int'(count) : slots_of(mode);
        n_items++;
      end
    end else if (drv_left > 0) begin
      drv_left--;
      n_items++;
    end
  endtask

  // Receiver back-pressure: stalls of random length separated by short open
  // windows, with calm stretches where the receiver never stalls.
  initial begin : stall_gen
    int len;
    forever begin
      if ($urandom_range(0, 39) == 0) stall_calm = !stall_calm;
      len = stall_calm ? 0 : gap_len();
      if (len > 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Scoreboard. Both channels are sampled at the rising edge, before the
  // nonblocking updates of that edge land, so the handshake is seen exactly
  // as the block saw it.
  always @(posedge clk_i) begin : scoreboard
    twjsm_result_t got, want, pred;
    bit            has_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.level_at_fall = level_at_fall_o;
        got.level_at_rise = level_at_rise_o;
        got.line_driven   = line_driven_o;
        got.op_done       = op_done_o;
        got.captured_word = captured_word_o;
        if (slot_q.size() == 0) begin
          $error("unexpected result transaction: 0x%0h", got);
          err_cnt++;
        end else begin
          want = slot_q.pop_front();
          check_field("level_at_fall", 20'(want.level_at_fall), 20'(got.level_at_fall));
          check_field("level_at_rise", 20'(want.level_at_rise), 20'(got.level_at_rise));
          check_field("line_driven", 20'(want.line_driven), 20'(got.line_driven));
          check_field("op_done", 20'(want.op_done), 20'(got.op_done));
          check_field("captured_word", want.captured_word, got.captured_word);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        has_res = scan_slot(mode_i, shift_data_i, strobe_count_i, line_sample_i, pred);
        case (pin_src)
          ExpFromModel: if (has_res) slot_q.push_back(pred);
          ExpTyped:     slot_q.push_back(pin_res);
          default:      ;
        endcase
      end
    end
  end

  // Watchdog: the slowest legal run is far below this count.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_two_wire_jtag_slot_master: FAIL");
      $finish;
    end
  end

  initial begin : main
    int          n_cmds;
    logic [2:0]  op;
    logic [StrobeWidth-1:0] cnt;
    n_cmds = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].count,
                dir_rows[i].sample, dir_rows[i].src, dir_rows[i].res);
    end

    // Random part. Mostly well-formed runs: a command followed by exactly
    // the ticks it needs, with random data and TDO levels. Mixed in are idle
    // ticks and commands thrown at a busy block, both of which must vanish.
    // The first seven commands walk every operation once.
    n_items = 0;
    while (n_items < RandomItems) begin
      if (drv_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(ModeTick, 20'($urandom_range(0, 20'hFFFFF)),
                    StrobeWidth'($urandom_range(0, 16'hFFFF)),
                    1'($urandom_range(0, 1)), ExpFromModel, '0);
        end else begin
          op = (n_cmds < 7) ? 3'(n_cmds + 1) : 3'($urandom_range(1, 7));
          n_cmds++;
          cnt = ($urandom_range(0, 7) == 0) ? '0 : StrobeWidth'($urandom_range(1, 3));
          send_item(op, 20'($urandom_range(0, 20'hFFFFF)), cnt,
                    1'($urandom_range(0, 1)), ExpFromModel, '0);
        end
      end else if ($urandom_range(0, 19) == 0) begin
        send_item(3'($urandom_range(1, 7)), 20'($urandom_range(0, 20'hFFFFF)),
                  StrobeWidth'($urandom_range(0, 16'hFFFF)),
                  1'($urandom_range(0, 1)), ExpFromModel, '0);
      end else begin
        send_item(ModeTick, 20'($urandom_range(0, 20'hFFFFF)),
                  StrobeWidth'($urandom_range(0, 16'hFFFF)),
                  1'($urandom_range(0, 1)), ExpFromModel, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Drain the results still in flight, then give stray ones a chance to
    // show up before the verdict.
    while (slot_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_two_wire_jtag_slot_master: PASS");
    end else begin
      $display("tb_two_wire_jtag_slot_master: FAIL");
    end
    $finish;
  end

endmodule

// ===== two_wire_jtag_slot_master.f =====
hw/rtl/twjsm_pkg.sv
hw/rtl/twjsm_out_buf.sv
hw/rtl/two_wire_jtag_slot_master.sv
verif/tb_two_wire_jtag_slot_master.sv
